// ===== hw/rtl/pqlsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pqlsc_pkg
// Shared types, constants and conversion functions of the paired quantized
// load/store conversion unit.
// ----------------------------------------------------------------------------
package pqlsc_pkg;

    // element type codes
    localparam logic [2:0] TYPE_FLOAT = 3'd0;
    localparam logic [2:0] TYPE_U8    = 3'd4;
    localparam logic [2:0] TYPE_U16   = 3'd5;
    localparam logic [2:0] TYPE_S8    = 3'd6;
    localparam logic [2:0] TYPE_S16   = 3'd7;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

    // per-lane control, same for both lanes
    typedef struct packed {
        logic       op;
        logic [2:0] data_type;
        logic [5:0] scale;
    } t_lane_ctrl;

    // dequantize a raw element: int to float then exact scale by 2^-e
    function automatic logic [31:0] f_dequant(input logic [31:0] raw,
                                              input logic [2:0] dt,
                                              input logic [5:0] sc);
        logic [16:0] mag;
        logic        sgn;
        logic [4:0]  lz;
        logic [16:0] norm;
        logic signed [9:0] ex;
        logic signed [6:0] e;
        logic        found;
        logic [31:0] res;
        mag = '0;
        sgn = 1'b0;
        lz = '0;
        found = 1'b0;
        res = '0;
        case (dt)
            TYPE_U8:  mag = {9'd0, raw[7:0]};
            TYPE_U16: mag = {1'b0, raw[15:0]};
            TYPE_S8: begin
                sgn = raw[7];
                mag = raw[7] ? 17'(9'd256 - {1'b0, raw[7:0]}) : {9'd0, raw[7:0]};
            end
            TYPE_S16: begin
                sgn = raw[15];
                mag = raw[15] ? 17'(17'h10000 - {1'b0, raw[15:0]}) : {1'b0, raw[15:0]};
            end
            default: mag = '0;
        endcase
        // leading one position over at most 17 bits
        for (int i = 16; i >= 0; i--) begin
            if (!found && mag[i]) begin
                lz = 5'(16 - i);
                found = 1'b1;
            end
        end
        norm = mag << lz;
        e = sc[5] ? $signed({1'b0, sc}) - 7'sd64 : $signed({1'b0, sc});
        // exponent of value: 16-lz, times 2^-e; biased
        ex = 10'sd127 + 10'sd16 - $signed({5'd0, lz}) - 10'(e);
        if (dt == TYPE_FLOAT)
            res = raw;
        else if (dt[2] == 1'b0)
            res = '0;
        else if (!found)
            res = '0;
        else if (ex <= 10'sd0) begin
            // denormal: small shift, exact since few mantissa bits used
            res = {sgn, 8'd0, 23'({norm[15:0], 7'd0} >> (10'sd1 - ex))};
        end else
            res = {sgn, ex[7:0], norm[15:0], 7'd0};
        return res;
    endfunction

    // quantize a float: scale by 2^e, clamp, truncate toward zero
    function automatic logic [31:0] f_quant(input logic [31:0] bits,
                                            input logic [2:0] dt,
                                            input logic [5:0] sc);
        logic        sgn;
        logic [7:0]  fe;
        logic [23:0] man;
        logic signed [10:0] ex;
        logic signed [6:0] e;
        logic [16:0] ip;
        logic [16:0] hi;
        logic [16:0] lo;
        logic        big;
        logic [16:0] v;
        logic [31:0] res;
        sgn = bits[31];
        fe = bits[30:23];
        man = {(fe != 8'd0), bits[22:0]};
        e = sc[5] ? $signed({1'b0, sc}) - 7'sd64 : $signed({1'b0, sc});
        // unbiased exponent after scaling (denormals treated via fe=1)
        ex = $signed({3'd0, (fe == 8'd0) ? 8'd1 : fe}) - 11'sd127 + 11'(e);
        big = 1'b0;
        ip = '0;
        if (ex > 11'sd16)
            big = 1'b1;
        else if (ex >= 11'sd0)
            ip = 17'(man >> (11'sd23 - ex));
        if (fe == 8'hFF) big = 1'b1;
        case (dt)
            TYPE_U8:  begin hi = 17'd255;   lo = 17'd0;     end
            TYPE_U16: begin hi = 17'd65535; lo = 17'd0;     end
            TYPE_S8:  begin hi = 17'd127;   lo = 17'd128;   end
            default:  begin hi = 17'd32767; lo = 17'd32768; end
        endcase
        res = '0;
        if (sgn) v = (big || ip > lo) ? lo : ip;
        else     v = (big || ip > hi) ? hi : ip;
        if (sgn) v = 17'(17'd0 - v);
        case (dt)
            TYPE_FLOAT: res = bits;
            TYPE_U8, TYPE_S8:   res = {24'd0, v[7:0]};
            TYPE_U16, TYPE_S16: res = {16'd0, v[15:0]};
            default: res = '0;
        endcase
        if (dt != TYPE_FLOAT && fe == 8'hFF && bits[22:0] != 23'd0) res = '0;
        return res;
    endfunction

endpackage

// ===== hw/rtl/paired_quantized_load_store_convert_unit.sv =====
// ----------------------------------------------------------------------------
// paired_quantized_load_store_convert_unit
// Two conversion lanes and a merge stage for paired quantized load/store.
// ----------------------------------------------------------------------------
// One item per cycle unless stalled: both elements are converted in
// parallel lanes into one output register, and a new beat is taken whenever
// that register is empty or being drained this cycle. The merge stage adds
// the effective address, stride, write count and the single-element rules.
module paired_quantized_load_store_convert_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: data_first[31:0], data_second[63:32], base_address[95:64],
    //        address_offset[127:96]
    input  logic [127:0] s_axis_tdata,
    // tuser: op[0], data_type[3:1], scale[9:4], single[10]
    input  logic [10:0]  s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: result_first[31:0], result_second[63:32],
    //        effective_address[95:64], stride[98:96], write_count[100:99],
    //        bad_type[101], zero fill to 103
    output logic [103:0] m_axis_tdata
);
    pqlsc_pkg::t_lane_ctrl w_ctrl;
    logic        w_take;
    logic        r_valid;
    logic [31:0] w_r0, w_r1;
    logic [31:0] r_ea;
    logic [2:0]  r_stride;
    logic [1:0]  r_wc;
    logic        r_bad, r_single, r_op;
    logic        w_bad;
    logic [2:0]  w_dt;

    assign w_ctrl = '{op: s_axis_tuser[0], data_type: s_axis_tuser[3:1],
                      scale: s_axis_tuser[9:4]};
    assign w_dt   = s_axis_tuser[3:1];
    assign w_bad  = (w_dt != pqlsc_pkg::TYPE_FLOAT) && !w_dt[2];
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_take = s_axis_tvalid && s_axis_tready;

    pqlsc_lane u_lane0 (.i_clk(i_clk), .i_en(w_take), .i_ctrl(w_ctrl),
                        .i_data(s_axis_tdata[31:0]), .o_data(w_r0));
    pqlsc_lane u_lane1 (.i_clk(i_clk), .i_en(w_take), .i_ctrl(w_ctrl),
                        .i_data(s_axis_tdata[63:32]), .o_data(w_r1));

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (s_axis_tready) r_valid <= s_axis_tvalid;
    end

    // side fields of the merge stage
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ea     <= s_axis_tdata[95:64] + s_axis_tdata[127:96];
            r_stride <= (w_dt == pqlsc_pkg::TYPE_U8 || w_dt == pqlsc_pkg::TYPE_S8) ? 3'd1 :
                        (w_dt == pqlsc_pkg::TYPE_U16 || w_dt == pqlsc_pkg::TYPE_S16) ? 3'd2 :
                        3'd4;
            r_wc     <= (s_axis_tuser[0] == pqlsc_pkg::OP_STORE && !w_bad) ?
                        (s_axis_tuser[10] ? 2'd1 : 2'd2) : 2'd0;
            r_bad    <= w_bad;
            r_single <= s_axis_tuser[10];
            r_op     <= s_axis_tuser[0];
        end
    end

    // merge: single-element rule for the second result
    logic [31:0] w_sec;
    assign w_sec = !r_single ? w_r1 :
                   (r_op == pqlsc_pkg::OP_LOAD) ? pqlsc_pkg::ONE_BITS : 32'd0;

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {2'd0, r_bad, r_wc, r_stride, r_ea, w_sec, w_r0};
endmodule

// ===== hw/rtl/pqlsc_lane.sv =====
// ----------------------------------------------------------------------------
// pqlsc_lane
// One conversion lane: dequantize on load, quantize on store, registered.
// ----------------------------------------------------------------------------
module pqlsc_lane (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  pqlsc_pkg::t_lane_ctrl i_ctrl,
    input  logic [31:0]           i_data,
    output logic [31:0]           o_data
);
    logic [31:0] r_data;
    logic [31:0] n_data;

    // select conversion by direction
    always_comb begin
        if (i_ctrl.op == pqlsc_pkg::OP_LOAD)
            n_data = pqlsc_pkg::f_dequant(i_data, i_ctrl.data_type, i_ctrl.scale);
        else
            n_data = pqlsc_pkg::f_quant(i_data, i_ctrl.data_type, i_ctrl.scale);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

// ===== hw/rtl/pqlsc_checker.sv =====
// ----------------------------------------------------------------------------
// pqlsc_checker
// Port-level checks of the conversion unit, bound to the top level.
// ----------------------------------------------------------------------------
module pqlsc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled beat changed");
    // accepted beat appears next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat lost");
    // ready when output free
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stall with empty output");
    // bad type never writes
    a_wc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[101] |-> m_axis_tdata[100:99] == 2'd0
        && m_axis_tdata[98:96] == 3'd4)
        else $error("bad type with writes");
endmodule

bind paired_quantized_load_store_convert_unit pqlsc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));

// ===== test/paired_quantized_load_store_convert_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_quantized_load_store_convert_unit_tb
// Self-checking bench for the paired quantized load/store conversion unit.
// Directed corner beats, then random loads and stores under several idle and
// stall mixes; every output beat is compared with a bit-exact predictor.
// ----------------------------------------------------------------------------
module paired_quantized_load_store_convert_unit_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 300;

    // reserved element type codes, flagged as bad by the block
    localparam logic [2:0] TYPE_BAD_LO  = 3'd1;
    localparam logic [2:0] TYPE_BAD_MID = 3'd2;
    localparam logic [2:0] TYPE_BAD_HI  = 3'd3;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
        logic [31:0] addr;
        logic [2:0]  stride;
        logic [1:0]  wcount;
        logic        bad;
    } t_convert_out;

    // conversion predictor and queue of pending beats
    class convert_scoreboard;
        t_convert_out pending[$];
        int errors = 0;

        function automatic logic [31:0] dequantize(logic [31:0] raw, logic [2:0] dt,
                                                   int e);
            int v;
            int mag;
            int p;
            logic [31:0] mant;
            case (dt)
                pqlsc_pkg::TYPE_FLOAT: return raw;
                pqlsc_pkg::TYPE_U8:  v = int'(raw[7:0]);
                pqlsc_pkg::TYPE_U16: v = int'(raw[15:0]);
                pqlsc_pkg::TYPE_S8:  v = int'($signed(raw[7:0]));
                pqlsc_pkg::TYPE_S16: v = int'($signed(raw[15:0]));
                default:  return '0;
            endcase
            if (v == 0) return '0;
            mag = (v < 0) ? -v : v;
            p = 0;
            for (int i = 0; i < 17; i++) if (mag[i]) p = i;
            mant = (32'(mag) << (23 - p)) & 32'h7F_FFFF;
            return {(v < 0), 8'(p - e + 127), mant[22:0]};
        endfunction

        function automatic logic [31:0] quantize(logic [31:0] b, logic [2:0] dt, int e);
            int hi;
            int lo;
            int fe;
            int ex;
            longint mag;
            longint v;
            logic [23:0] man;
            case (dt)
                pqlsc_pkg::TYPE_FLOAT: return b;
                pqlsc_pkg::TYPE_U8:  begin lo = 0;      hi = 255;   end
                pqlsc_pkg::TYPE_U16: begin lo = 0;      hi = 65535; end
                pqlsc_pkg::TYPE_S8:  begin lo = -128;   hi = 127;   end
                pqlsc_pkg::TYPE_S16: begin lo = -32768; hi = 32767; end
                default:  return '0;
            endcase
            fe = int'(b[30:23]);
            // nan gives zero, infinity clamps
            if (fe == 255 && b[22:0] != 0) return '0;
            man = {(fe != 0), b[22:0]};
            ex = ((fe == 0) ? 1 : fe) - 127 + e;
            if (fe == 255 || ex > 16) mag = 64'd1 << 20;
            else if (ex >= 0) mag = longint'(man >> (23 - ex));
            else mag = 0;
            v = b[31] ? -mag : mag;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return (dt == pqlsc_pkg::TYPE_U16 || dt == pqlsc_pkg::TYPE_S16) ?
                   {16'd0, 16'(v)} : {24'd0, 8'(v)};
        endfunction

        // work out the expected beat of one accepted input beat
        function void note_input(logic [127:0] d, logic [10:0] u);
            t_convert_out x;
            logic        op;
            logic [2:0]  dt;
            logic [5:0]  sc;
            logic        sgl;
            int e;
            op = u[0];
            dt = u[3:1];
            sc = u[9:4];
            sgl = u[10];
            e = sc[5] ? int'(sc) - 64 : int'(sc);
            x.bad = (dt >= TYPE_BAD_LO && dt <= TYPE_BAD_HI);
            x.addr = d[95:64] + d[127:96];
            x.stride = (dt == pqlsc_pkg::TYPE_U8 || dt == pqlsc_pkg::TYPE_S8) ? 3'd1 :
                       (dt == pqlsc_pkg::TYPE_U16 || dt == pqlsc_pkg::TYPE_S16) ? 3'd2 :
                       3'd4;
            x.wcount = 2'd0;
            if (op == pqlsc_pkg::OP_LOAD) begin
                x.first = dequantize(d[31:0], dt, e);
                x.second = sgl ? pqlsc_pkg::ONE_BITS : dequantize(d[63:32], dt, e);
            end else begin
                x.first = quantize(d[31:0], dt, e);
                x.second = sgl ? 32'd0 : quantize(d[63:32], dt, e);
                if (!x.bad) x.wcount = sgl ? 2'd1 : 2'd2;
            end
            pending.push_back(x);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(logic [103:0] r);
            t_convert_out x;
            if (pending.size() == 0) begin
                report("unexpected beat", r[31:0], 32'd0);
                return;
            end
            x = pending.pop_front();
            if (r[31:0] !== x.first) report("result_first", r[31:0], x.first);
            if (r[63:32] !== x.second) report("result_second", r[63:32], x.second);
            if (r[95:64] !== x.addr) report("effective_address", r[95:64], x.addr);
            if (r[98:96] !== x.stride) report("stride", 32'(r[98:96]), 32'(x.stride));
            if (r[100:99] !== x.wcount) report("write_count", 32'(r[100:99]), 32'(x.wcount));
            if (r[101] !== x.bad) report("bad_type", 32'(r[101]), 32'(x.bad));
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [10:0]  s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;

    convert_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_used = 1'b0;
    int hold_cycles = 0;
    int cycle_count = 0;

    paired_quantized_load_store_convert_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver ready, with a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_go && !hold_used) begin
            hold_cycles <= HOLD_LEN - 1;
            hold_used <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // output beats checked mid-cycle, where handshake signals are settled
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // one input beat; called and returns at a rising edge
    task send_beat(logic op, logic [2:0] dt, logic [5:0] sc, logic sgl,
                   logic [31:0] d0, logic [31:0] d1, logic [31:0] base,
                   logic [31:0] offs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {offs, base, d1, d0};
        s_axis_tuser <= {sgl, sc, dt, op};
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
            @(posedge i_clk);
        end
        sb.note_input({offs, base, d1, d0}, {sgl, sc, dt, op});
        @(posedge i_clk);
    endtask

    // float operand for stores: exponents mostly from 100 to 160 or random, some specials
    function automatic logic [31:0] store_value();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(9))
            0: b[30:0] = 31'h7F80_0000;
            1: b[30:23] = 8'hFF;
            2: b[30:23] = 8'h00;
            3: b[30:0] = '0;
            4, 5: ;
            default: b[30:23] = 8'($urandom_range(100, 160));
        endcase
        return b;
    endfunction

    task random_beats(int count);
        logic op;
        logic [2:0] dt;
        for (int i = 0; i < count; i++) begin
            op = 1'($urandom_range(1));
            dt = ($urandom_range(9) == 0) ? 3'($urandom_range(1, 3)) :
                 (($urandom_range(4) == 0) ? pqlsc_pkg::TYPE_FLOAT :
                  3'($urandom_range(4, 7)));
            if (op == pqlsc_pkg::OP_LOAD)
                send_beat(op, dt, 6'($urandom), ($urandom_range(3) == 0), $urandom, $urandom,
                          $urandom, $urandom);
            else
                send_beat(op, dt, 6'($urandom), ($urandom_range(3) == 0), store_value(),
                          store_value(), $urandom, $urandom);
        end
    endtask

    task drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: every type, both ops, scale extremes, specials
        send_beat(pqlsc_pkg::OP_LOAD, pqlsc_pkg::TYPE_U8, 6'd0, 1'b0, 32'hFFFF_FFFF, 32'h0,
                  32'hFFFF_FFFF, 32'h1);
        send_beat(pqlsc_pkg::OP_LOAD, pqlsc_pkg::TYPE_U16, 6'd31, 1'b0, 32'h0000_FFFF, 32'h1,
                  32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_LOAD, pqlsc_pkg::TYPE_S8, 6'd32, 1'b0, 32'h80, 32'h7F,
                  32'h1234, 32'hFFFF_FFFC);
        send_beat(pqlsc_pkg::OP_LOAD, pqlsc_pkg::TYPE_S16, 6'd63, 1'b0, 32'h8000, 32'hFFFF,
                  32'h8000_0000, 32'h8000_0000);
        send_beat(pqlsc_pkg::OP_LOAD, pqlsc_pkg::TYPE_FLOAT, 6'd5, 1'b0, 32'h7FC0_0001,
                  32'h8000_0000, 32'h10, 32'h20);
        send_beat(pqlsc_pkg::OP_LOAD, pqlsc_pkg::TYPE_S16, 6'd3, 1'b1, 32'h7FFF, 32'h1234,
                  32'h0, 32'h4);
        send_beat(pqlsc_pkg::OP_LOAD, TYPE_BAD_LO, 6'd0, 1'b0, 32'h55, 32'hAA, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_LOAD, TYPE_BAD_HI, 6'd0, 1'b1, 32'h55, 32'hAA, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, pqlsc_pkg::TYPE_FLOAT, 6'd7, 1'b0, 32'h4049_0FDB,
                  32'hFF80_0000, 32'h4, 32'h8);
        send_beat(pqlsc_pkg::OP_STORE, pqlsc_pkg::TYPE_U8, 6'd0, 1'b0, 32'h7FC0_0000,
                  32'h7F80_0000, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, pqlsc_pkg::TYPE_U8, 6'd0, 1'b0, 32'hBF80_0000,
                  32'h437F_0000, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, pqlsc_pkg::TYPE_U16, 6'd31, 1'b0, 32'h3F80_0000,
                  32'h4780_0000, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, pqlsc_pkg::TYPE_S8, 6'd32, 1'b0, 32'hFF80_0000,
                  32'hC300_0000, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, pqlsc_pkg::TYPE_S8, 6'd63, 1'b0, 32'hBFC0_0000,
                  32'h42FE_0000, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, pqlsc_pkg::TYPE_S16, 6'd0, 1'b0, 32'hC700_0000,
                  32'h46FF_FE00, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, pqlsc_pkg::TYPE_S16, 6'd1, 1'b1, 32'hC6FF_FE00,
                  32'h3F80_0000, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, pqlsc_pkg::TYPE_U16, 6'd0, 1'b0, 32'h0000_0001,
                  32'h8000_0001, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, TYPE_BAD_MID, 6'd9, 1'b0, 32'h4000_0000,
                  32'h4000_0000, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, TYPE_BAD_LO, 6'd9, 1'b1, 32'h4000_0000,
                  32'h4000_0000, 32'h0, 32'h0);
        send_beat(pqlsc_pkg::OP_STORE, pqlsc_pkg::TYPE_U8, 6'd0, 1'b1, 32'h42C8_0000,
                  32'h42C8_0000, 32'h0, 32'h0);

        // random phases over the idle and stall mixes
        random_beats(350);
        send_idle_pct = 85;
        random_beats(250);
        send_idle_pct = 0;
        recv_stall_pct = 85;
        random_beats(250);
        send_idle_pct = 27;
        recv_stall_pct = 27;
        random_beats(250);

        // receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go = 1'b1;
        random_beats(280);

        s_axis_tvalid <= 1'b0;
        drain();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
